// ===== hw/rtl/hostname_syntax_checker_macros.svh =====
// Assertion macros for the hostname syntax checker.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef HOSTNAME_SYNTAX_CHECKER_MACROS_SVH
`define HOSTNAME_SYNTAX_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
// Checked while the synchronous reset is released.
`define HSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("hostname syntax checker assertion failed");
// Checked at every clock edge, reset included.
`define HSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("hostname syntax checker assertion failed");
`else
`define HSC_ASSERT(lbl, clk, rst_n, prop)
`define HSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/hsc_pkg.sv =====
// Package for the hostname syntax checker: status codes, counter widths,
// length limits and delimiter characters. No dependencies.
`timescale 1ns / 1ps

package hsc_pkg;

    localparam int unsigned LABEL_W   = 7;
    localparam int unsigned NAME_W    = 9;
    localparam int unsigned MAX_LABEL = 63;
    localparam int unsigned MAX_NAME  = 255;

    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_NUL        = 8'h00;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_LABEL_LONG = 3'd2,
        ST_BAD_DOT    = 3'd3,
        ST_BAD_HYPHEN = 3'd4,
        ST_BAD_CHAR   = 3'd5,
        ST_NUMERIC    = 3'd6,
        ST_TOO_LONG   = 3'd7
    } t_status;

endpackage

// ===== hw/rtl/hostname_syntax_checker.sv =====
// Hostname syntax checker top level: per-byte label and name checks, one status per name.
// Depends on hsc_pkg and hostname_syntax_checker_macros.svh.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_in_char_byte, i_in_is_last
//   out     | output    | o_out_valid / i_out_stall | o_out_status
//
// A new byte can be accepted in every cycle, unless it is a last byte held back by o_in_stall.
// The status of a name appears in the output register in the cycle after its last byte is taken.
// The status is graded combinationally from the name state and the last byte, then registered.
// Reset (i_rst_n low at a clock edge) clears the name state and the output valid flag; the status value is not reset.
// While a status waits under i_out_stall, bytes that are not last are still accepted;
// only a last byte is held back until the output register is free.
`timescale 1ns / 1ps
`include "hostname_syntax_checker_macros.svh"

module hostname_syntax_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char_byte,
    input  logic       i_in_is_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_out_status
);

    localparam int unsigned LW = hsc_pkg::LABEL_W;
    localparam int unsigned NW = hsc_pkg::NAME_W;

    // Name state. The pending flags stand in for a one-byte lookahead: a dot or
    // hyphen is only judged once the following byte, or the end of the name, is seen.
    logic [LW-1:0]        r_label_len, n_label_len;
    logic [NW-1:0]        r_name_len, n_name_len;
    logic                 r_has_letter, n_has_letter;
    hsc_pkg::t_status     r_first_error, n_first_error;
    logic                 r_ended, n_ended;
    logic                 r_hyphen_pending, n_hyphen_pending;
    logic                 r_dot_pending, n_dot_pending;
    logic                 r_seen_any, n_seen_any;

    // Output register.
    logic                 r_out_valid;
    hsc_pkg::t_status     r_status, n_status;

    logic                 w_in_accept;
    logic                 w_is_digit;
    logic                 w_is_word;
    logic [LW-1:0]        w_label_inc;
    logic [NW-1:0]        w_name_inc;

    // A last byte needs the output register; other bytes never do.
    assign o_in_stall  = r_out_valid && i_out_stall && i_in_is_last;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_status;

    // Character classes: digits, and the bytes that may extend a label.
    assign w_is_digit = (i_in_char_byte >= 8'h30) && (i_in_char_byte <= 8'h39);
    assign w_is_word  = w_is_digit
                     || ((i_in_char_byte >= 8'h61) && (i_in_char_byte <= 8'h7A))
                     || ((i_in_char_byte >= 8'h41) && (i_in_char_byte <= 8'h5A))
                     || (i_in_char_byte == hsc_pkg::CHAR_UNDERSCORE);

    // Saturating increments of the two length counters.
    assign w_label_inc = (r_label_len == {LW{1'b1}}) ? r_label_len : r_label_len + LW'(1);
    assign w_name_inc  = (r_name_len == {NW{1'b1}}) ? r_name_len : r_name_len + NW'(1);

    always_comb begin
        n_label_len      = r_label_len;
        n_name_len       = r_name_len;
        n_has_letter     = r_has_letter;
        n_first_error    = r_first_error;
        n_ended          = r_ended;
        n_hyphen_pending = r_hyphen_pending;
        n_dot_pending    = r_dot_pending;
        n_seen_any       = r_seen_any;
        n_status         = hsc_pkg::ST_OK;

        if (!r_ended && (r_first_error == hsc_pkg::ST_OK)) begin
            if (i_in_char_byte == hsc_pkg::CHAR_NUL) begin
                // Early terminator: a name with no byte before it is empty,
                // otherwise any delimiter still pending is a trailing one.
                if (!r_seen_any) begin
                    n_first_error = hsc_pkg::ST_EMPTY;
                end else if (r_dot_pending) begin
                    n_first_error = hsc_pkg::ST_BAD_DOT;
                end else if (r_hyphen_pending) begin
                    n_first_error = hsc_pkg::ST_BAD_HYPHEN;
                end
                n_dot_pending    = 1'b0;
                n_hyphen_pending = 1'b0;
                n_ended          = 1'b1;
            end else begin
                n_seen_any = 1'b1;
                if (r_hyphen_pending && (i_in_char_byte == hsc_pkg::CHAR_DOT)) begin
                    // A hyphen may not end a label.
                    n_first_error = hsc_pkg::ST_BAD_HYPHEN;
                end else begin
                    n_hyphen_pending = 1'b0;
                    n_dot_pending    = 1'b0;
                    priority if (w_is_word) begin
                        n_label_len = w_label_inc;
                        if (32'(w_label_inc) > hsc_pkg::MAX_LABEL) begin
                            n_first_error = hsc_pkg::ST_LABEL_LONG;
                        end else begin
                            if (!w_is_digit) begin
                                n_has_letter = 1'b1;
                            end
                            n_name_len = w_name_inc;
                        end
                    end else if (i_in_char_byte == hsc_pkg::CHAR_DOT) begin
                        // A dot needs a non-empty label in front of it.
                        if (r_label_len == '0) begin
                            n_first_error = hsc_pkg::ST_BAD_DOT;
                        end else begin
                            n_label_len   = '0;
                            n_dot_pending = 1'b1;
                            n_name_len    = w_name_inc;
                        end
                    end else if (i_in_char_byte == hsc_pkg::CHAR_HYPHEN) begin
                        // A hyphen counts toward the label but may not open it.
                        n_has_letter = 1'b1;
                        n_label_len  = w_label_inc;
                        if (w_label_inc == LW'(1)) begin
                            n_first_error = hsc_pkg::ST_BAD_HYPHEN;
                        end else begin
                            n_hyphen_pending = 1'b1;
                            n_name_len       = w_name_inc;
                        end
                    end else begin
                        n_first_error = hsc_pkg::ST_BAD_CHAR;
                    end
                end
            end
        end else if (i_in_char_byte == hsc_pkg::CHAR_NUL) begin
            n_ended = 1'b1;
        end

        // End of the name: settle a trailing delimiter, then grade the name.
        // Only the last byte closes the name; a pending flag otherwise waits.
        if (i_in_is_last && (n_first_error == hsc_pkg::ST_OK) && !n_ended) begin
            if (n_dot_pending) begin
                n_first_error = hsc_pkg::ST_BAD_DOT;
            end else if (n_hyphen_pending) begin
                n_first_error = hsc_pkg::ST_BAD_HYPHEN;
            end
        end

        priority if (n_first_error != hsc_pkg::ST_OK) begin
            n_status = n_first_error;
        end else if (!n_seen_any) begin
            n_status = hsc_pkg::ST_EMPTY;
        end else if (!n_has_letter) begin
            n_status = hsc_pkg::ST_NUMERIC;
        end else if (32'(n_name_len) > hsc_pkg::MAX_NAME) begin
            n_status = hsc_pkg::ST_TOO_LONG;
        end else begin
            n_status = hsc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_len      <= '0;
            r_name_len       <= '0;
            r_has_letter     <= 1'b0;
            r_first_error    <= hsc_pkg::ST_OK;
            r_ended          <= 1'b0;
            r_hyphen_pending <= 1'b0;
            r_dot_pending    <= 1'b0;
            r_seen_any       <= 1'b0;
        end else if (w_in_accept) begin
            if (i_in_is_last) begin
                // The status is out; start clean for the next name.
                r_label_len      <= '0;
                r_name_len       <= '0;
                r_has_letter     <= 1'b0;
                r_first_error    <= hsc_pkg::ST_OK;
                r_ended          <= 1'b0;
                r_hyphen_pending <= 1'b0;
                r_dot_pending    <= 1'b0;
                r_seen_any       <= 1'b0;
            end else begin
                r_label_len      <= n_label_len;
                r_name_len       <= n_name_len;
                r_has_letter     <= n_has_letter;
                r_first_error    <= n_first_error;
                r_ended          <= n_ended;
                r_hyphen_pending <= n_hyphen_pending;
                r_dot_pending    <= n_dot_pending;
                r_seen_any       <= n_seen_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept && i_in_is_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && i_in_is_last) begin
            r_status <= n_status;
        end
    end

    // A status only appears after a last byte was taken.
    `HSC_ASSERT(a_status_after_last, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_in_accept && i_in_is_last))
    // Taking a last byte leaves the name state clean.
    `HSC_ASSERT(a_clear_after_last, i_clk, i_rst_n, (w_in_accept && i_in_is_last) |=> ((r_name_len == '0) && !r_seen_any && (r_first_error == hsc_pkg::ST_OK)))
    // Once an error is recorded it stays until the name ends.
    `HSC_ASSERT(a_error_sticky, i_clk, i_rst_n, ((r_first_error != hsc_pkg::ST_OK) && !(w_in_accept && i_in_is_last)) |=> ((r_first_error == $past(r_first_error)) && $stable(r_label_len)))

endmodule
